// ===== rtl/grot_pkg.sv =====
package grot_pkg;

    // field width and the Q1.30 fraction of cos and sin
    localparam int DATA_W     = 32;
    localparam int Q_FRAC     = 30;
    localparam int QUO_W      = Q_FRAC + 1;
    localparam int RAD_W      = 2 * Q_FRAC + 2;
    // quotient bits after the first one, and root bits
    localparam int DIV_STEPS  = Q_FRAC;
    localparam int SQRT_STEPS = Q_FRAC + 1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE_Q30 = DATA_W'(1) << Q_FRAC;

    // values that ride along the stages up to the cos and sin selection
    typedef struct packed {
        logic                     func;
        logic                     ymz;
        logic                     neg;
        logic                     ybig;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] cs_in;
        logic signed [DATA_W-1:0] sn_in;
        logic        [QUO_W-1:0]  t;
    } side_t;

    // restoring divider state
    typedef struct packed {
        side_t             side;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_t;

    // digit-by-digit square root state
    typedef struct packed {
        side_t            side;
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] root;
    } sqrt_t;

endpackage

// ===== rtl/grot_div_step.sv =====
module grot_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          valid_i,
    input  grot_pkg::div_t d_i,
    output logic          valid_o,
    output grot_pkg::div_t d_o
);
    import grot_pkg::*;

    logic              valid_reg;
    div_t              d_reg;
    div_t              d_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    // one quotient bit per stage
    always_comb begin
        shifted     = {d_i.rem, 1'b0};
        diff        = shifted - {1'b0, d_i.den};
        ge          = shifted >= {1'b0, d_i.den};
        d_next      = d_i;
        d_next.rem  = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        d_next.quo  = {d_i.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign valid_o = valid_reg;
    assign d_o     = d_reg;

endmodule

// ===== rtl/grot_sqrt_step.sv =====
module grot_sqrt_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        valid_i,
    input  logic [grot_pkg::RAD_W-1:0]  bit_i,
    input  grot_pkg::sqrt_t             s_i,
    output logic                        valid_o,
    output grot_pkg::sqrt_t             s_o
);
    import grot_pkg::*;

    logic             valid_reg;
    sqrt_t            s_reg;
    sqrt_t            s_next;
    logic [RAD_W-1:0] trial;
    logic             ge;

    // one root bit per stage
    always_comb begin
        trial  = s_i.root + bit_i;
        ge     = s_i.rad >= trial;
        s_next = s_i;
        if (ge) begin
            s_next.rad  = s_i.rad - trial;
            s_next.root = (s_i.root >> 1) + bit_i;
        end else begin
            s_next.root = s_i.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
        end
    end

    assign valid_o = valid_reg;
    assign s_o     = s_reg;

endmodule

// ===== rtl/givens_rotation_unit.sv =====
// channel | direction | ports
// s_      | in        | s_valid, s_ready, s_func, s_in_x, s_in_y, s_cos_in, s_sin_in
// m_      | out       | m_valid, m_ready, m_cos_out, m_sin_out, m_out_x, m_out_y, m_saturated
//
// one item per cycle unless the output stalls; the two 31-step restoring
// dividers and the 31-step square root make one bit per stage
// aresetn (synchronous) clears all valid bits; data registers keep no reset
// the whole pipeline holds while a result waits and m_ready is low
module givens_rotation_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic signed [grot_pkg::DATA_W-1:0]  s_in_x,
    input  logic signed [grot_pkg::DATA_W-1:0]  s_in_y,
    input  logic signed [grot_pkg::DATA_W-1:0]  s_cos_in,
    input  logic signed [grot_pkg::DATA_W-1:0]  s_sin_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [grot_pkg::DATA_W-1:0]  m_cos_out,
    output logic signed [grot_pkg::DATA_W-1:0]  m_sin_out,
    output logic signed [grot_pkg::DATA_W-1:0]  m_out_x,
    output logic signed [grot_pkg::DATA_W-1:0]  m_out_y,
    output logic                                m_saturated
);
    import grot_pkg::*;

    localparam int PROD_W = 2 * DATA_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RSH_W  = SUM_W - Q_FRAC;

    logic en;

    // input register
    logic  v1_reg;
    side_t s1_reg;
    side_t s1_next;

    // magnitudes and ordering
    logic              v2_reg;
    side_t             s2_reg;
    side_t             s2_next;
    logic [DATA_W-1:0] small2_reg;
    logic [DATA_W-1:0] small2_next;
    logic [DATA_W-1:0] big2_reg;
    logic [DATA_W-1:0] big2_next;
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;

    // ratio divider
    logic dvalid [0:DIV_STEPS];
    div_t dchain [0:DIV_STEPS];
    div_t d0_next;

    // square and radicand
    logic             vsq_reg;
    side_t            ssq_reg;
    side_t            ssq_next;
    logic [RAD_W-1:0] sq_reg;
    logic [RAD_W-1:0] sq_next;
    logic             svalid [0:SQRT_STEPS];
    sqrt_t            schain [0:SQRT_STEPS];
    sqrt_t            sq0_next;

    // reciprocal divider
    logic rvalid [0:DIV_STEPS];
    div_t rchain [0:DIV_STEPS];
    div_t r0_next;
    logic [QUO_W-1:0] root_q;

    // t * r
    logic                   vtr_reg;
    side_t                  str_reg;
    logic [QUO_W-1:0]       r_reg;
    logic [2*QUO_W-1:0]     tr_reg;
    logic [2*QUO_W-1:0]     tr_next;

    // cos and sin selection
    logic                     vsel_reg;
    logic signed [DATA_W-1:0] cs_reg;
    logic signed [DATA_W-1:0] cs_next;
    logic signed [DATA_W-1:0] sn_reg;
    logic signed [DATA_W-1:0] sn_next;
    logic signed [DATA_W-1:0] xs_reg;
    logic signed [DATA_W-1:0] ys_reg;
    logic                     func_sel_reg;
    logic [2*QUO_W-1:0]       o_full;
    logic [DATA_W-1:0]        o_mag;

    // products
    logic                     vmul_reg;
    logic signed [DATA_W-1:0] csm_reg;
    logic signed [DATA_W-1:0] snm_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [PROD_W-1:0] p1_next, p2_next, p3_next, p4_next;
    logic signed [DATA_W:0]   nsn;

    // rounded sums
    logic                     vsum_reg;
    logic signed [DATA_W-1:0] css_reg;
    logic signed [DATA_W-1:0] sns_reg;
    logic signed [RSH_W-1:0]  rx_reg, ry_reg;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [RSH_W-1:0]  rx_next, ry_next;

    // output register
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_cos_reg, m_sin_reg, m_x_reg, m_y_reg;
    logic signed [DATA_W-1:0] m_x_next, m_y_next;
    logic                     m_sat_reg;
    logic                     m_sat_next;
    logic                     sat_x, sat_y;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: capture item
    always_comb begin
        s1_next       = '0;
        s1_next.func  = s_func;
        s1_next.x     = s_in_x;
        s1_next.y     = s_in_y;
        s1_next.cs_in = s_cos_in;
        s1_next.sn_in = s_sin_in;
    end

    // stage 2: magnitudes, sign, which element is larger
    always_comb begin
        ax           = s1_reg.x[DATA_W-1] ? DATA_W'(-s1_reg.x) : DATA_W'(s1_reg.x);
        ay           = s1_reg.y[DATA_W-1] ? DATA_W'(-s1_reg.y) : DATA_W'(s1_reg.y);
        s2_next      = s1_reg;
        s2_next.ymz  = (s1_reg.y == '0);
        s2_next.neg  = s1_reg.x[DATA_W-1] ^ s1_reg.y[DATA_W-1];
        s2_next.ybig = ay > ax;
        small2_next  = (ay > ax) ? ax : ay;
        big2_next    = (ay > ax) ? ay : ax;
    end

    // stage 3: top quotient bit of small / big
    always_comb begin
        d0_next.side = s2_reg;
        d0_next.den  = big2_reg;
        if (small2_reg >= big2_reg) begin
            d0_next.rem = small2_reg - big2_reg;
            d0_next.quo = QUO_W'(1);
        end else begin
            d0_next.rem = small2_reg;
            d0_next.quo = '0;
        end
    end

    // square of the ratio
    always_comb begin
        ssq_next   = dchain[DIV_STEPS].side;
        ssq_next.t = dchain[DIV_STEPS].quo;
        sq_next    = RAD_W'(dchain[DIV_STEPS].quo) * RAD_W'(dchain[DIV_STEPS].quo);
    end

    // radicand one + t^2
    always_comb begin
        sq0_next.side = ssq_reg;
        sq0_next.rad  = (RAD_W'(1) << (2 * Q_FRAC)) + sq_reg;
        sq0_next.root = '0;
    end

    // top bit of one / root
    always_comb begin
        root_q       = schain[SQRT_STEPS].root[QUO_W-1:0];
        r0_next.side = schain[SQRT_STEPS].side;
        r0_next.den  = DATA_W'(root_q);
        if (DATA_W'(ONE_Q30) >= DATA_W'(root_q)) begin
            r0_next.rem = DATA_W'(ONE_Q30) - DATA_W'(root_q);
            r0_next.quo = QUO_W'(1);
        end else begin
            r0_next.rem = DATA_W'(ONE_Q30);
            r0_next.quo = '0;
        end
    end

    assign tr_next = (2*QUO_W)'(rchain[DIV_STEPS].side.t) * (2*QUO_W)'(rchain[DIV_STEPS].quo);

    // pick cos and sin
    always_comb begin
        o_full = (tr_reg + ((2*QUO_W)'(1) << (Q_FRAC - 1))) >> Q_FRAC;
        o_mag  = o_full[DATA_W-1:0];
        if (str_reg.func) begin
            cs_next = str_reg.cs_in;
            sn_next = str_reg.sn_in;
        end else if (str_reg.ymz) begin
            cs_next = ONE_Q30;
            sn_next = '0;
        end else if (str_reg.ybig) begin
            sn_next = DATA_W'(r_reg);
            cs_next = str_reg.neg ? DATA_W'(-o_mag) : o_mag;
        end else begin
            cs_next = DATA_W'(r_reg);
            sn_next = str_reg.neg ? DATA_W'(-o_mag) : o_mag;
        end
    end

    // four products
    always_comb begin
        nsn     = -(DATA_W+1)'(sn_reg);
        p1_next = PROD_W'(cs_reg) * PROD_W'(xs_reg);
        p2_next = PROD_W'(sn_reg) * PROD_W'(ys_reg);
        p3_next = PROD_W'(nsn) * PROD_W'(xs_reg);
        p4_next = PROD_W'(cs_reg) * PROD_W'(ys_reg);
    end

    // sum and round half up
    always_comb begin
        sum_x   = SUM_W'(p1_reg) + SUM_W'(p2_reg) + (SUM_W'(1) << (Q_FRAC - 1));
        sum_y   = SUM_W'(p3_reg) + SUM_W'(p4_reg) + (SUM_W'(1) << (Q_FRAC - 1));
        rx_next = RSH_W'(sum_x >>> Q_FRAC);
        ry_next = RSH_W'(sum_y >>> Q_FRAC);
    end

    // saturate
    always_comb begin
        sat_x = (rx_reg > RSH_W'(SAT_MAX)) || (rx_reg < RSH_W'(SAT_MIN));
        sat_y = (ry_reg > RSH_W'(SAT_MAX)) || (ry_reg < RSH_W'(SAT_MIN));
        if (rx_reg > RSH_W'(SAT_MAX)) begin
            m_x_next = SAT_MAX;
        end else if (rx_reg < RSH_W'(SAT_MIN)) begin
            m_x_next = SAT_MIN;
        end else begin
            m_x_next = rx_reg[DATA_W-1:0];
        end
        if (ry_reg > RSH_W'(SAT_MAX)) begin
            m_y_next = SAT_MAX;
        end else if (ry_reg < RSH_W'(SAT_MIN)) begin
            m_y_next = SAT_MIN;
        end else begin
            m_y_next = ry_reg[DATA_W-1:0];
        end
        m_sat_next = sat_x || sat_y;
    end

    // valid bits of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            dvalid[0]   <= 1'b0;
            vsq_reg     <= 1'b0;
            svalid[0]   <= 1'b0;
            rvalid[0]   <= 1'b0;
            vtr_reg     <= 1'b0;
            vsel_reg    <= 1'b0;
            vmul_reg    <= 1'b0;
            vsum_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            dvalid[0]   <= v2_reg;
            vsq_reg     <= dvalid[DIV_STEPS];
            svalid[0]   <= vsq_reg;
            rvalid[0]   <= svalid[SQRT_STEPS];
            vtr_reg     <= rvalid[DIV_STEPS];
            vsel_reg    <= vtr_reg;
            vmul_reg    <= vsel_reg;
            vsum_reg    <= vmul_reg;
            m_valid_reg <= vsum_reg;
        end
    end

    // data registers of the top-level stages
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            small2_reg   <= small2_next;
            big2_reg     <= big2_next;
            dchain[0]    <= d0_next;
            ssq_reg      <= ssq_next;
            sq_reg       <= sq_next;
            schain[0]    <= sq0_next;
            rchain[0]    <= r0_next;
            str_reg      <= rchain[DIV_STEPS].side;
            r_reg        <= rchain[DIV_STEPS].quo;
            tr_reg       <= tr_next;
            cs_reg       <= cs_next;
            sn_reg       <= sn_next;
            xs_reg       <= str_reg.x;
            ys_reg       <= str_reg.y;
            func_sel_reg <= str_reg.func;
            csm_reg      <= cs_reg;
            snm_reg      <= sn_reg;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            p4_reg       <= p4_next;
            css_reg      <= csm_reg;
            sns_reg      <= snm_reg;
            rx_reg       <= rx_next;
            ry_reg       <= ry_next;
            m_cos_reg    <= css_reg;
            m_sin_reg    <= sns_reg;
            m_x_reg      <= m_x_next;
            m_y_reg      <= m_y_next;
            m_sat_reg    <= m_sat_next;
        end
    end

    // ratio divider steps
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        grot_div_step u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (dvalid[i]),
            .d_i     (dchain[i]),
            .valid_o (dvalid[i+1]),
            .d_o     (dchain[i+1])
        );
    end

    // square root steps
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        grot_sqrt_step u_sqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (svalid[i]),
            .bit_i   (RAD_W'(1) << (2 * Q_FRAC - 2 * i)),
            .s_i     (schain[i]),
            .valid_o (svalid[i+1]),
            .s_o     (schain[i+1])
        );
    end

    // reciprocal divider steps
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_rcp
        grot_div_step u_rcp (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (rvalid[i]),
            .d_i     (rchain[i]),
            .valid_o (rvalid[i+1]),
            .d_o     (rchain[i+1])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_cos_out   = m_cos_reg;
    assign m_sin_out   = m_sin_reg;
    assign m_out_x     = m_x_reg;
    assign m_out_y     = m_y_reg;
    assign m_saturated = m_sat_reg;

    // nothing valid comes out right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a generated rotation never exceeds one in magnitude
    a_gen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vsel_reg && !func_sel_reg |-> (cs_reg <= ONE_Q30) && (cs_reg >= -ONE_Q30)
                                      && (sn_reg <= ONE_Q30) && (sn_reg >= -ONE_Q30))
        else $error("generated cos or sin out of range");

    // a clipped result sits at a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_out_x == SAT_MAX) || (m_out_x == SAT_MIN)
                                   || (m_out_y == SAT_MAX) || (m_out_y == SAT_MIN))
        else $error("saturation flag without a clipped value");

endmodule
